// ===== sv/xmcr_pkg.sv =====
// ----------------------------------------------------------------------------
// xmcr_pkg
// Shared codes and constants for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xmcr_pkg;

  // Fixed packet geometry
  localparam int PAYLOAD_BYTES = 128;

  // Port widths fixed by the interface
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int COUNT_W    = 17;

  // Link control characters
  localparam logic [7:0] SOH_CODE = 8'h01;
  localparam logic [7:0] EOT_CODE = 8'h04;
  localparam logic [7:0] ACK_CODE = 8'h06;
  localparam logic [7:0] NAK_CODE = 8'h15;
  localparam logic [7:0] CAN_CODE = 8'h18;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUF_CAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_TO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NAK_INT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT = 3'd4;

  // Session end codes
  localparam logic [2:0] END_NONE     = 3'd0;
  localparam logic [2:0] END_COMPLETE = 3'd1;
  localparam logic [2:0] END_RX_CAN   = 3'd2;
  localparam logic [2:0] END_ERRORS   = 3'd3;
  localparam logic [2:0] END_IDLE     = 3'd4;
  localparam logic [2:0] END_TX_CAN   = 3'd5;

  // Packet check flag bit positions
  localparam int FLG_NUM  = 0;
  localparam int FLG_COMP = 1;
  localparam int FLG_SUM  = 2;
  localparam int FLG_TIME = 3;

  // Between-packet marker bit positions
  localparam int SEEN_EOT = 0;
  localparam int SEEN_CAN = 1;

endpackage

// ===== sv/xmodem_checksum_receiver.sv =====
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// XMODEM receiver, 8-bit additive checksum, 128-byte packets.
// ----------------------------------------------------------------------------
// Takes one received byte or one millisecond tick per beat and answers with
// ACK, NAK or a double CAN, plus a store beat per payload byte with its
// buffer address. A new input beat is taken every cycle while the result
// queue has room; results pass through the input register and a two-entry
// result queue, so a stalled output does not stop input until both entries
// are full. An overflow or a bad packet number gives two result beats (CAN,
// CAN) from one input. Configuration must be written through the cfg_ port
// only while the block is idle; the block itself does not enforce this.
module xmodem_checksum_receiver #(
  parameter int ADDR_BITS  = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [xmcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xmcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [7:0]                      in_rx_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_tx_valid,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_store_valid,
  output logic [ADDR_BITS-1:0]            out_store_addr,
  output logic [7:0]                      out_store_byte,
  output logic                            out_packet_accepted,
  output logic [2:0]                      out_end_code,
  output logic [xmcr_pkg::COUNT_W-1:0]    out_byte_count,
  output logic                            out_last
);
  import xmcr_pkg::*;

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int ASUM_W = ((ADDR_BITS > COUNT_W) ? ADDR_BITS : COUNT_W) + 1;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  typedef struct packed {
    logic [7:0]           tx_byte;
    logic                 store_valid;
    logic [ADDR_BITS-1:0] store_addr;
    logic [7:0]           store_byte;
    logic                 pkt_acc;
    logic [2:0]           end_code;
    logic [COUNT_W-1:0]   byte_count;
    logic                 twice;
  } rec_t;

  // Configuration registers
  logic [16:0] buf_cap_r;
  logic [15:0] byte_to_r;
  logic [15:0] idle_to_r;
  logic [15:0] nak_int_r;
  logic [3:0]  err_lim_r;

  // Input register
  logic       in_valid_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;

  // Protocol state
  logic                  phase_r,   phase_nxt;
  logic [7:0]            bidx_r,    bidx_nxt;
  logic [7:0]            exp_r,     exp_nxt;
  logic [7:0]            got_r,     got_nxt;
  logic [7:0]            sum_r,     sum_nxt;
  logic [3:0]            flags_r,   flags_nxt;
  logic [1:0]            seen_r,    seen_nxt;
  logic [3:0]            err_r,     err_nxt;
  logic [COUNT_W-1:0]    acc_r,     acc_nxt;
  logic [TIMER_BITS-1:0] sil_r,     sil_nxt;
  logic [TIMER_BITS-1:0] nak_r,     nak_nxt;

  // Result queue
  rec_t       rec_q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       half_r;

  logic                  adv;
  logic                  rec_push;
  rec_t                  rec;
  rec_t                  head;
  logic                  pop;
  logic                  beat;
  logic [TIMER_BITS-1:0] nak_inc;
  logic [TIMER_BITS-1:0] sil_inc;
  logic                  do_fin;
  logic                  bad;
  logic                  err_hit;
  logic                  new_sess;
  logic                  nak_max;
  logic [ASUM_W-1:0]     addr_full;
  logic [COUNT_W:0]      acc_need;

  // Advance the input stage whenever the queue has room
  assign adv      = in_valid_r && (cnt_r != 2'd2);
  assign in_stall = in_valid_r && (cnt_r == 2'd2);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cap_r <= 17'h10000;
      byte_to_r <= 16'd10000;
      idle_to_r <= 16'd1;
      nak_int_r <= 16'd10000;
      err_lim_r <= 4'd10;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BUF_CAP:   buf_cap_r <= cfg_wdata;
        REG_BYTE_TO:   byte_to_r <= cfg_wdata[15:0];
        REG_IDLE_TO:   idle_to_r <= cfg_wdata[15:0];
        REG_NAK_INT:   nak_int_r <= cfg_wdata[15:0];
        REG_ERR_LIMIT: err_lim_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r   <= in_opcode;
      in_byte_r <= in_rx_byte;
    end
  end

  // One protocol step per input beat
  always_comb begin
    phase_nxt = phase_r;
    bidx_nxt  = bidx_r;
    exp_nxt   = exp_r;
    got_nxt   = got_r;
    sum_nxt   = sum_r;
    flags_nxt = flags_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    acc_nxt   = acc_r;
    sil_nxt   = sil_r;
    nak_nxt   = nak_r;
    rec       = '0;
    rec_push  = 1'b0;
    do_fin    = 1'b0;
    new_sess  = 1'b0;
    nak_max   = 1'b0;

    nak_inc   = (nak_r == TMAX) ? nak_r : nak_r + 1'b1;
    sil_inc   = (sil_r == TMAX) ? sil_r : sil_r + 1'b1;
    addr_full = ASUM_W'(acc_r) + ASUM_W'(bidx_r) - ASUM_W'(2);
    acc_need  = {1'b0, acc_r} + (COUNT_W+1)'(PAYLOAD_BYTES);
    err_hit   = ({1'b0, err_r} + 5'd1) >= {1'b0, err_lim_r};

    if (in_op_r == OP_TICK) begin
      // Tick: age the timers, then check the active timeout
      nak_nxt = nak_inc;
      sil_nxt = sil_inc;
      if (phase_r) begin
        if (CMP_W'(sil_inc) >= CMP_W'(byte_to_r)) begin
          flags_nxt[FLG_TIME] = 1'b1;
          do_fin = 1'b1;
        end
      end else if (CMP_W'(sil_inc) >= CMP_W'(idle_to_r)) begin
        rec_push       = 1'b1;
        rec.end_code   = END_IDLE;
        rec.byte_count = acc_r;
        if (CMP_W'(nak_inc) >= CMP_W'(nak_int_r)) begin
          rec.tx_byte = NAK_CODE;
          nak_nxt     = '0;
        end
        new_sess = 1'b1;
      end
    end else begin
      sil_nxt = '0;
      if (phase_r) begin
        // Inside a packet: number, complement, payload, checksum
        bidx_nxt = bidx_r + 8'd1;
        if (bidx_r == 8'd0) begin
          got_nxt = in_byte_r;
          if (in_byte_r != exp_r) flags_nxt[FLG_NUM] = 1'b1;
        end else if (bidx_r == 8'd1) begin
          if (in_byte_r != ~exp_r) flags_nxt[FLG_NUM] = 1'b1;
          if (in_byte_r != ~got_r) flags_nxt[FLG_COMP] = 1'b1;
        end else if (bidx_r < 8'(2 + PAYLOAD_BYTES)) begin
          sum_nxt          = sum_r + in_byte_r;
          rec_push         = 1'b1;
          rec.store_valid  = 1'b1;
          rec.store_addr   = addr_full[ADDR_BITS-1:0];
          rec.store_byte   = in_byte_r;
          rec.byte_count   = acc_r;
        end else begin
          if (sum_r != in_byte_r) flags_nxt[FLG_SUM] = 1'b1;
          do_fin = 1'b1;
        end
      end else if (in_byte_r == EOT_CODE) begin
        // End of transfer needs two EOTs
        rec_push       = 1'b1;
        rec.byte_count = acc_r;
        if (seen_r[SEEN_EOT]) begin
          rec.tx_byte  = ACK_CODE;
          rec.end_code = END_COMPLETE;
          new_sess     = 1'b1;
          nak_max      = 1'b1;
        end else begin
          seen_nxt[SEEN_EOT] = 1'b1;
          rec.tx_byte        = NAK_CODE;
        end
      end else if (in_byte_r == CAN_CODE) begin
        // Sender cancel needs two CANs
        if (seen_r[SEEN_CAN]) begin
          rec_push       = 1'b1;
          rec.end_code   = END_TX_CAN;
          rec.byte_count = acc_r;
          if (CMP_W'(nak_r) >= CMP_W'(nak_int_r)) begin
            rec.tx_byte = NAK_CODE;
            nak_nxt     = '0;
          end
          new_sess = 1'b1;
        end else begin
          seen_nxt[SEEN_CAN] = 1'b1;
        end
      end else if (in_byte_r == SOH_CODE) begin
        // Header: cancel on overflow, else open a packet
        if (acc_need > {1'b0, buf_cap_r}) begin
          rec_push       = 1'b1;
          rec.tx_byte    = CAN_CODE;
          rec.end_code   = END_RX_CAN;
          rec.byte_count = acc_r;
          rec.twice      = 1'b1;
          new_sess       = 1'b1;
          nak_max        = 1'b1;
        end else begin
          seen_nxt  = '0;
          phase_nxt = 1'b1;
          bidx_nxt  = '0;
          flags_nxt = '0;
          sum_nxt   = '0;
          got_nxt   = '0;
        end
      end
    end

    // Packet end: run the checks in priority order
    bad = flags_nxt[FLG_COMP] || flags_nxt[FLG_TIME] || flags_nxt[FLG_SUM];
    if (do_fin) begin
      phase_nxt      = 1'b0;
      sil_nxt        = '0;
      rec_push       = 1'b1;
      rec.byte_count = acc_r;
      if (bad && err_hit) begin
        rec.end_code = END_ERRORS;
        new_sess     = 1'b1;
        nak_max      = 1'b1;
      end else if (!flags_nxt[FLG_COMP] && flags_nxt[FLG_NUM]) begin
        if (got_r == exp_r - 8'd1) begin
          rec.tx_byte = ACK_CODE;
        end else begin
          rec.tx_byte  = CAN_CODE;
          rec.end_code = END_RX_CAN;
          rec.twice    = 1'b1;
          new_sess     = 1'b1;
          nak_max      = 1'b1;
        end
      end else if (bad) begin
        if (err_r != 4'hF) err_nxt = err_r + 4'd1;
        rec.tx_byte = NAK_CODE;
      end else begin
        acc_nxt        = acc_r + COUNT_W'(PAYLOAD_BYTES);
        exp_nxt        = exp_r + 8'd1;
        err_nxt        = '0;
        rec.tx_byte    = ACK_CODE;
        rec.pkt_acc    = 1'b1;
        rec.byte_count = acc_nxt;
      end
    end

    // Restart the session
    if (new_sess) begin
      phase_nxt = 1'b0;
      bidx_nxt  = '0;
      exp_nxt   = 8'd1;
      got_nxt   = '0;
      sum_nxt   = '0;
      flags_nxt = '0;
      seen_nxt  = '0;
      err_nxt   = '0;
      acc_nxt   = '0;
      sil_nxt   = '0;
    end
    if (nak_max) nak_nxt = TMAX;
  end

  // Protocol state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      bidx_r  <= '0;
      exp_r   <= 8'd1;
      got_r   <= '0;
      sum_r   <= '0;
      flags_r <= '0;
      seen_r  <= '0;
      err_r   <= '0;
      acc_r   <= '0;
      sil_r   <= '0;
      nak_r   <= TMAX;
    end else if (adv) begin
      phase_r <= phase_nxt;
      bidx_r  <= bidx_nxt;
      exp_r   <= exp_nxt;
      got_r   <= got_nxt;
      sum_r   <= sum_nxt;
      flags_r <= flags_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
      acc_r   <= acc_nxt;
      sil_r   <= sil_nxt;
      nak_r   <= nak_nxt;
    end
  end

  // Result queue: a doubled record drains as two beats
  assign head = rec_q_r[rd_ptr_r];
  assign beat = out_valid && !out_stall;
  assign pop  = beat && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      if (adv && rec_push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        half_r   <= 1'b0;
      end else if (beat) begin
        half_r <= 1'b1;
      end
      cnt_r <= cnt_r + {1'b0, adv && rec_push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rec_push) rec_q_r[wr_ptr_r] <= rec;
  end

  // Drive the result ports from the queue head
  assign out_valid           = (cnt_r != 2'd0);
  assign out_tx_valid        = (head.tx_byte != 8'd0);
  assign out_tx_byte         = head.tx_byte;
  assign out_store_valid     = head.store_valid;
  assign out_store_addr      = head.store_addr;
  assign out_store_byte      = head.store_byte;
  assign out_packet_accepted = head.pkt_acc;
  assign out_end_code        = head.end_code;
  assign out_byte_count      = head.byte_count;
  assign out_last            = !head.twice || half_r;

endmodule

// ===== sv/xmcr_checker.sv =====
// ----------------------------------------------------------------------------
// xmcr_checker
// Port-level checks for the XMODEM checksum receiver, bound to the top level.
// ----------------------------------------------------------------------------
module xmcr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_store_valid,
  input logic       out_packet_accepted,
  input logic [2:0] out_end_code,
  input logic       out_last
);
  import xmcr_pkg::*;

  // First beat of a CAN pair is followed by its partner
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && out_tx_byte == CAN_CODE && out_end_code == END_RX_CAN)
    else $error("second CAN beat missing");

  // A store beat carries no reply and no session end
  a_store_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_valid |-> !out_tx_valid && out_end_code == END_NONE)
    else $error("store beat with reply or end code");

  // An accepted packet is always acknowledged
  a_accept_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_accepted |-> out_tx_byte == ACK_CODE)
    else $error("accepted packet without ACK");

  // Hold the result while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte)
      && $stable(out_end_code) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind xmodem_checksum_receiver xmcr_checker u_xmcr_checker (.*);
